// File: src/whd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// whd_pkg
// Shared constants, types and helper functions of the waypoint planner.
// ----------------------------------------------------------------------------
package whd_pkg;

   localparam int TABLE_DEPTH  = 32;
   localparam int COORD_BITS   = 8;
   localparam int IDX_BITS     = $clog2(TABLE_DEPTH);
   localparam int TC_BITS      = 6;
   localparam int SLOT_BITS    = 5;
   localparam int CNT_BITS     = (IDX_BITS + 1 > TC_BITS) ? IDX_BITS + 1 : TC_BITS;

   localparam int FRAC_BITS    = 16;
   localparam int XY_BITS      = COORD_BITS + FRAC_BITS + 4;
   localparam int ANGLE_BITS   = 23;
   localparam int Z_BITS       = 25;
   localparam int CORDIC_STEPS = 16;

   localparam int ROOT_BITS    = COORD_BITS + 9;
   localparam int N_BITS       = 2 * ROOT_BITS;
   localparam int REM_BITS     = ROOT_BITS + 3;
   localparam int STEP_BITS    = $clog2(ROOT_BITS);

   localparam int HEADING_BITS = 16;
   localparam int DIST_BITS    = 17;
   localparam int DIST_MAX     = (2 ** DIST_BITS) - 1;
   localparam int DEG90        = 90 * 128;
   localparam int DEG180       = 180 * 128;
   localparam int Z_90         = 90 * 65536;
   localparam int ROUND_SHIFT  = 9;
   localparam int ROUND_HALF   = 256;

   typedef struct packed {
      logic load;
      logic scan_start;
      logic scan_next;
      logic setup_leg;
      logic setup_home;
      logic iterate;
      logic emit;
      logic emit_home;
   } whd_cmd_type;

   typedef struct packed {
      logic scan_end;
      logic scan_hit;
      logic home_now;
      logic iter_last;
      logic out_free;
   } whd_status_type;

   // atan(2^-i) in 2^-16 degree
   function automatic logic [ANGLE_BITS-1:0] cordic_angle(input logic [3:0] i);
      logic [ANGLE_BITS-1:0] a;
      unique case (i)
         4'd0:  a = ANGLE_BITS'(2949120);
         4'd1:  a = ANGLE_BITS'(1740967);
         4'd2:  a = ANGLE_BITS'(919879);
         4'd3:  a = ANGLE_BITS'(466945);
         4'd4:  a = ANGLE_BITS'(234379);
         4'd5:  a = ANGLE_BITS'(117304);
         4'd6:  a = ANGLE_BITS'(58666);
         4'd7:  a = ANGLE_BITS'(29335);
         4'd8:  a = ANGLE_BITS'(14668);
         4'd9:  a = ANGLE_BITS'(7334);
         4'd10: a = ANGLE_BITS'(3667);
         4'd11: a = ANGLE_BITS'(1833);
         4'd12: a = ANGLE_BITS'(917);
         4'd13: a = ANGLE_BITS'(458);
         4'd14: a = ANGLE_BITS'(229);
         4'd15: a = ANGLE_BITS'(115);
         default: a = '0;
      endcase
      return a;
   endfunction

   // arithmetic shift that truncates toward zero
   function automatic logic signed [XY_BITS-1:0] shift_down(
      input logic signed [XY_BITS-1:0] v,
      input logic [3:0]                s
   );
      logic [XY_BITS-1:0] mag;
      logic [XY_BITS-1:0] res;
      mag = v[XY_BITS-1] ? (~v + 1'b1) : v;
      res = mag >> s;
      if (v[XY_BITS-1]) res = ~res + 1'b1;
      return signed'(res);
   endfunction

endpackage
`default_nettype wire

// File: src/whd_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// whd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module whd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: src/whd_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// whd_datapath
// Target table, position, shared CORDIC and square-root units, result register.
// ----------------------------------------------------------------------------
module whd_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire whd_pkg::whd_cmd_type                cmd,
   output whd_pkg::whd_status_type                  status,
   input  wire logic                                csr_valid,
   input  wire logic [whd_pkg::TC_BITS-1:0]         csr_target_count,
   input  wire logic [whd_pkg::SLOT_BITS-1:0]       req_slot,
   input  wire logic [whd_pkg::COORD_BITS-1:0]      req_target_x,
   input  wire logic [whd_pkg::COORD_BITS-1:0]      req_target_y,
   input  wire logic                                req_pending,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_valid,
   output logic signed [whd_pkg::HEADING_BITS-1:0]  rsp_heading,
   output logic [whd_pkg::DIST_BITS-1:0]            rsp_distance,
   output logic                                     rsp_home_leg,
   output logic                                     rsp_last
);
   import whd_pkg::*;

   localparam int CB = COORD_BITS;

   // control state
   logic [TC_BITS-1:0]     tc_ff;
   logic [TABLE_DEPTH-1:0] pend_ff;
   logic [CB-1:0]          pos_x_ff, pos_y_ff;
   logic [TC_BITS-1:0]     visited_ff;
   logic                   rsp_valid_ff;

   // work registers
   logic [CNT_BITS-1:0]        idx_ff;
   logic [STEP_BITS-1:0]       step_ff;
   logic signed [XY_BITS-1:0]  cx_ff, cy_ff;
   logic signed [Z_BITS-1:0]   cz_ff;
   logic [N_BITS-1:0]          n_ff;
   logic [REM_BITS-1:0]        rem_ff;
   logic [ROOT_BITS-1:0]       root_ff;
   logic                       hx_zero_ff, right_ff, below_ff, above_ff;
   logic signed [HEADING_BITS-1:0] heading_ff;
   logic [DIST_BITS-1:0]       distance_ff;
   logic                       home_leg_ff, last_ff;

   // table
   logic [CNT_BITS-1:0] slot_ext, scan_len, tc_ext;
   logic                slot_ok;
   logic                wr_en;
   logic [IDX_BITS-1:0] wr_addr;
   logic [2*CB-1:0]     wr_data, rd_data;
   logic [CB-1:0]       gx, gy;

   assign slot_ext = CNT_BITS'(req_slot);
   assign slot_ok  = slot_ext < CNT_BITS'(TABLE_DEPTH);
   assign tc_ext   = CNT_BITS'(tc_ff);
   assign scan_len = (tc_ext > CNT_BITS'(TABLE_DEPTH)) ? CNT_BITS'(TABLE_DEPTH) : tc_ext;
   assign gx       = rd_data[2*CB-1:CB];
   assign gy       = rd_data[CB-1:0];

   // leg setup: unit step toward the position along the larger axis, y on a tie
   logic [CB-1:0]   hx0, hy0, mtx, mty, mhx, mhy, tx, ty, hx, hy;
   logic [2*CB-1:0] hx_sq, hy_sq;
   logic [2*CB:0]   sq;
   logic [N_BITS-1:0] n_init;

   always_comb begin
      hx0 = (gx > pos_x_ff) ? gx - pos_x_ff : pos_x_ff - gx;
      hy0 = (gy > pos_y_ff) ? gy - pos_y_ff : pos_y_ff - gy;
      mtx = gx;
      mty = gy;
      mhx = hx0;
      mhy = hy0;
      if (hy0 >= hx0) begin
         if (hy0 != '0) begin
            mhy = hy0 - 1'b1;
            mty = (gy >= pos_y_ff) ? gy - 1'b1 : gy + 1'b1;
         end
      end else begin
         mhx = hx0 - 1'b1;
         mtx = (gx >= pos_x_ff) ? gx - 1'b1 : gx + 1'b1;
      end
      if (cmd.setup_home) begin
         tx = '0;
         ty = '0;
         hx = pos_x_ff;
         hy = pos_y_ff;
      end else begin
         tx = mtx;
         ty = mty;
         hx = mhx;
         hy = mhy;
      end
      hx_sq  = hx * hx;
      hy_sq  = hy * hy;
      sq     = {1'b0, hx_sq} + {1'b0, hy_sq};
      n_init = N_BITS'({sq, {FRAC_BITS{1'b0}}});
   end

   assign wr_en   = (cmd.load && slot_ok) || cmd.setup_leg;
   assign wr_addr = cmd.setup_leg ? idx_ff[IDX_BITS-1:0] : slot_ext[IDX_BITS-1:0];
   assign wr_data = cmd.setup_leg ? {tx, ty} : {req_target_x, req_target_y};

   whd_ram #(
      .WIDTH (2 * CB),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_ff[IDX_BITS-1:0]),
      .rd_data (rd_data)
   );

   // each iterate cycle: one root digit, and a CORDIC step if step < 16 and y != 0
   logic [3:0]                sft;
   logic                      cordic_on;
   logic signed [XY_BITS-1:0] sx, sy;
   logic signed [Z_BITS-1:0]  ang;
   logic [REM_BITS-1:0]       raw, trial;
   logic                      digit;

   always_comb begin
      sft       = step_ff[3:0];
      cordic_on = (step_ff < STEP_BITS'(CORDIC_STEPS)) && (cy_ff != '0);
      sx        = shift_down(cx_ff, sft);
      sy        = shift_down(cy_ff, sft);
      ang       = Z_BITS'(cordic_angle(sft));
      raw       = {rem_ff[REM_BITS-3:0], n_ff[N_BITS-1 -: 2]};
      trial     = REM_BITS'({root_ff, 2'b01});
      digit     = raw >= trial;
   end

   // result formatting
   logic [Z_BITS-2:0]             zc;
   logic [Z_BITS-1:0]             zr;
   logic signed [HEADING_BITS-1:0] a, deg90, deg180, head;
   logic [ROOT_BITS:0]            dist_r;

   always_comb begin
      deg90  = HEADING_BITS'(DEG90);
      deg180 = HEADING_BITS'(DEG180);
      if (cz_ff[Z_BITS-1]) begin
         zc = '0;
      end else if (cz_ff[Z_BITS-2:0] > (Z_BITS-1)'(Z_90)) begin
         zc = (Z_BITS-1)'(Z_90);
      end else begin
         zc = cz_ff[Z_BITS-2:0];
      end
      zr = {1'b0, zc} + Z_BITS'(ROUND_HALF);
      a  = HEADING_BITS'(zr >> ROUND_SHIFT);
      if (hx_zero_ff) begin
         head = above_ff ? '0 : deg180;
      end else if (right_ff) begin
         head = below_ff ? (-deg90 - a) : (a - deg90);
      end else begin
         head = below_ff ? (a + deg90) : (deg90 - a);
      end
      dist_r = {1'b0, root_ff} + (ROOT_BITS+1)'(rem_ff > REM_BITS'(root_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tc_ff        <= '0;
         pend_ff      <= '0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         visited_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            tc_ff <= csr_target_count;
         end
         if (cmd.load && slot_ok) begin
            pend_ff[slot_ext[IDX_BITS-1:0]] <= req_pending;
         end
         if (cmd.setup_leg) begin
            pend_ff[idx_ff[IDX_BITS-1:0]] <= 1'b0;
            pos_x_ff   <= tx;
            pos_y_ff   <= ty;
            visited_ff <= visited_ff + 1'b1;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_start) begin
         idx_ff <= '0;
      end else if (cmd.scan_next) begin
         idx_ff <= idx_ff + 1'b1;
      end
      if (cmd.setup_leg || cmd.setup_home) begin
         cx_ff      <= XY_BITS'({hx, {FRAC_BITS{1'b0}}});
         cy_ff      <= XY_BITS'({hy, {FRAC_BITS{1'b0}}});
         cz_ff      <= '0;
         n_ff       <= n_init;
         rem_ff     <= '0;
         root_ff    <= '0;
         step_ff    <= '0;
         hx_zero_ff <= (hx == '0);
         right_ff   <= tx > pos_x_ff;
         below_ff   <= ty < pos_y_ff;
         above_ff   <= ty > pos_y_ff;
      end else if (cmd.iterate) begin
         step_ff <= step_ff + 1'b1;
         if (cordic_on) begin
            if (!cy_ff[XY_BITS-1]) begin
               cx_ff <= cx_ff + sy;
               cy_ff <= cy_ff - sx;
               cz_ff <= cz_ff + ang;
            end else begin
               cx_ff <= cx_ff - sy;
               cy_ff <= cy_ff + sx;
               cz_ff <= cz_ff - ang;
            end
         end
         n_ff    <= n_ff << 2;
         rem_ff  <= digit ? raw - trial : raw;
         root_ff <= {root_ff[ROOT_BITS-2:0], digit};
      end
      if (cmd.emit) begin
         heading_ff  <= head;
         distance_ff <= (dist_r > (ROOT_BITS+1)'(DIST_MAX)) ? DIST_BITS'(DIST_MAX)
                                                           : DIST_BITS'(dist_r);
         home_leg_ff <= cmd.emit_home;
         last_ff     <= cmd.emit_home || !status.home_now;
      end
   end

   always_comb begin
      status.scan_end  = idx_ff >= scan_len;
      status.scan_hit  = pend_ff[idx_ff[IDX_BITS-1:0]];
      status.home_now  = (tc_ff != '0) && (visited_ff == TC_BITS'(tc_ff - 1'b1));
      status.iter_last = step_ff == STEP_BITS'(ROOT_BITS - 1);
      status.out_free  = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_heading  = heading_ff;
   assign rsp_distance = distance_ff;
   assign rsp_home_leg = home_leg_ff;
   assign rsp_last     = last_ff;

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff)
      else $error("result register not loaded");

   a_leg_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.setup_leg |=> !pend_ff[$past(idx_ff[IDX_BITS-1:0])])
      else $error("visited slot still pending");

endmodule
`default_nettype wire

// File: src/whd_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// whd_ctrl
// Sequencer: slot scan, leg setup, iteration, result hand-off, origin leg.
// ----------------------------------------------------------------------------
module whd_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic                    req_action,
   output logic                         req_ready,
   input  wire whd_pkg::whd_status_type status,
   output whd_pkg::whd_cmd_type         cmd
);
   import whd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_READ,
      ST_ITER,
      ST_EMIT,
      ST_HOME_CHECK
   } state_type;

   state_type state_ff, state_in;
   logic      home_ff, home_in;

   always_comb begin
      state_in  = state_ff;
      home_in   = home_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_action) begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_SCAN;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            priority if (status.scan_end) begin
               state_in = ST_HOME_CHECK;
            end else if (status.scan_hit) begin
               state_in = ST_READ;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         ST_READ: begin
            cmd.setup_leg = 1'b1;
            home_in       = 1'b0;
            state_in      = ST_ITER;
         end
         ST_ITER: begin
            cmd.iterate = 1'b1;
            if (status.iter_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_home = home_ff;
               state_in      = home_ff ? ST_IDLE : ST_HOME_CHECK;
            end
         end
         ST_HOME_CHECK: begin
            if (status.home_now) begin
               cmd.setup_home = 1'b1;
               home_in        = 1'b1;
               state_in       = ST_ITER;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         home_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         home_ff  <= home_in;
      end
   end

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("result overwritten");

   a_setup_iter: assert property (@(posedge clock) disable iff (reset)
      (cmd.setup_leg || cmd.setup_home) |=> cmd.iterate)
      else $error("setup not followed by iteration");

endmodule
`default_nettype wire

// File: src/waypoint_heading_distance.sv
`default_nettype none
// ----------------------------------------------------------------------------
// waypoint_heading_distance
// Route planner: target table, next-leg heading and distance, origin return.
// ----------------------------------------------------------------------------
// Usage:
//   csr_* writes target_count (slots scanned per plan item, at most 32).
//   Write it only while the block is idle; csr_ready is always high.
//   req_* carries one item: action 0 loads slot/target_x/target_y/pending
//   into the table and produces no result. Action 1 plans the next leg
//   and yields zero, one or two rsp_* items.
//   Plan sequence: the scan walks one slot per cycle (up to 32), then one
//   table read sets up the leg, then the CORDIC unit and the square-root
//   unit iterate together, then the result register is loaded, then the
//   origin check runs; a scan that finds no pending slot goes straight to
//   the origin check. An origin leg adds another iterate and load pass
//   before the sequencer is idle and takes the next item. The scan and the
//   shared iterative units set the rate; one item is worked at a time.
//   The result sits in an output register. While the receiver stalls, the
//   sequencer waits only when it has a new result to load and the previous
//   one is still held; no input item is taken while it waits.
//   Reset (synchronous, active high) clears target_count, pending marks,
//   position and visited count; table coordinates stay undefined until
//   loaded.
// ----------------------------------------------------------------------------
module waypoint_heading_distance (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // configuration
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [whd_pkg::TC_BITS-1:0]         csr_target_count,
   // input items
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_action,
   input  wire logic [whd_pkg::SLOT_BITS-1:0]       req_slot,
   input  wire logic [whd_pkg::COORD_BITS-1:0]      req_target_x,
   input  wire logic [whd_pkg::COORD_BITS-1:0]      req_target_y,
   input  wire logic                                req_pending,
   // result items
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [whd_pkg::HEADING_BITS-1:0]  rsp_heading,
   output logic [whd_pkg::DIST_BITS-1:0]            rsp_distance,
   output logic                                     rsp_home_leg,
   output logic                                     rsp_last
);
   import whd_pkg::*;

   whd_cmd_type    cmd;
   whd_status_type status;

   // register writes are never stalled
   assign csr_ready = 1'b1;

   whd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   whd_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_valid        (csr_valid),
      .csr_target_count (csr_target_count),
      .req_slot         (req_slot),
      .req_target_x     (req_target_x),
      .req_target_y     (req_target_y),
      .req_pending      (req_pending),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_heading      (rsp_heading),
      .rsp_distance     (rsp_distance),
      .rsp_home_leg     (rsp_home_leg),
      .rsp_last         (rsp_last)
   );

endmodule
`default_nettype wire

// File: test/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for waypoint_heading_distance. A directed table runs
// first, then random route phases: loads of targets followed by plan items
// and noise items, under several target counts. Each accepted item updates a
// local planner model whose legs queue up and are matched in order at rsp_*.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import whd_pkg::*;

   localparam int ITEM_GOAL  = 600;
   localparam int IDLE_GAP   = 100;
   localparam int HOLD_LEN   = 400;
   localparam int CYCLE_CAP  = 1000000;
   localparam int ACT_LOAD   = 0;
   localparam int ACT_PLAN   = 1;

   typedef struct {
      logic signed [HEADING_BITS-1:0] heading;
      logic [DIST_BITS-1:0]           distance;
      logic                           home_leg;
      logic                           last;
   } leg_t;

   typedef struct {
      bit       action;
      bit [4:0] slot;
      bit [7:0] tx;
      bit [7:0] ty;
      bit       pend;
      bit       typed;       // first leg given by hand
      leg_t     leg;
   } row_t;

   localparam longint ATAN_TBL [16] = '{
      2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115};

   logic clock, reset;
   logic csr_valid, csr_ready;
   logic [TC_BITS-1:0] csr_target_count;
   logic req_valid, req_ready, req_action, req_pending;
   logic [SLOT_BITS-1:0] req_slot;
   logic [COORD_BITS-1:0] req_target_x, req_target_y;
   logic rsp_valid, rsp_ready;
   logic signed [HEADING_BITS-1:0] rsp_heading;
   logic [DIST_BITS-1:0] rsp_distance;
   logic rsp_home_leg, rsp_last;

   waypoint_heading_distance dut (.*);

   // planner model state
   bit [5:0] route_count;
   bit [7:0] tab_x [32];
   bit [7:0] tab_y [32];
   bit       tab_pend [32];
   bit [7:0] here_x, here_y;
   bit [5:0] visited_cnt;

   leg_t legs_due [$];
   int   errors = 0;
   int   cycles = 0;
   int   items_sent = 0;
   bit   hold_go = 0;

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic longint trunc_shr(longint v, int s);
      return (v >= 0) ? (v >>> s) : -((-v) >>> s);
   endfunction

   // CORDIC vectoring, result in 1/128 degree clamped to 0..90
   function automatic int atan_128(int hy, int hx);
      longint x, y, z, nx;
      x = longint'(hx) * 65536;
      y = longint'(hy) * 65536;
      z = 0;
      for (int i = 0; i < 16; i++) begin
         if (y == 0) break;
         if (y > 0) begin
            nx = x + trunc_shr(y, i);
            y  = y - trunc_shr(x, i);
            z += ATAN_TBL[i];
         end else begin
            nx = x - trunc_shr(y, i);
            y  = y + trunc_shr(x, i);
            z -= ATAN_TBL[i];
         end
         x = nx;
      end
      if (z < 0) z = 0;
      if (z > 90 * 65536) z = 90 * 65536;
      return int'((z + 256) >>> 9);
   endfunction

   function automatic int dist_256(int hx, int hy);
      longint unsigned n, r, bitv, rem;
      n = (longint'(hx) * hx + longint'(hy) * hy) << 16;
      r = 0;
      bitv = 64'd1 << 62;
      rem = n;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (rem >= r + bitv) begin
            rem -= r + bitv;
            r = (r >> 1) + bitv;
         end else begin
            r >>= 1;
         end
         bitv >>= 2;
      end
      if (n - r * r > r) r++;
      return (r > DIST_MAX) ? DIST_MAX : int'(r);
   endfunction

   // leg from the current position to goal (gx, gy)
   function automatic leg_t make_leg(int gx, int gy, int hx, int hy, bit home, bit fin);
      leg_t l;
      int h, a;
      if (hx == 0) begin
         h = (gy > here_y) ? 0 : DEG180;
      end else begin
         a = atan_128(hy, hx);
         if (gx > here_x) h = (gy < here_y) ? (-DEG90 - a) : (a - DEG90);
         else             h = (gy < here_y) ? (a + DEG90) : (DEG90 - a);
      end
      l.heading  = h[15:0];
      l.distance = 17'(dist_256(hx, hy));
      l.home_leg = home;
      l.last     = fin;
      return l;
   endfunction

   function automatic bit home_due();
      return route_count != 0 && visited_cnt == route_count - 6'd1;
   endfunction

   // planner model: one accepted item
   function automatic void plan_step(bit act, bit [4:0] s, bit [7:0] x, bit [7:0] y, bit p);
      int found, scan, gx, gy, hx, hy;
      bit home;
      if (act == ACT_LOAD) begin
         tab_x[s] = x;
         tab_y[s] = y;
         tab_pend[s] = p;
         return;
      end
      found = -1;
      scan = (route_count < 32) ? route_count : 32;
      for (int i = 0; i < scan; i++)
         if (tab_pend[i]) begin
            found = i;
            break;
         end
      if (found >= 0) begin
         gx = tab_x[found];
         gy = tab_y[found];
         hx = (gx > here_x) ? gx - here_x : here_x - gx;
         hy = (gy > here_y) ? gy - here_y : here_y - gy;
         tab_pend[found] = 0;
         // one unit short along the larger axis
         if (hy >= hx) begin
            if (hy > 0) begin
               hy--;
               if (gy >= here_y) gy--; else gy++;
            end
         end else begin
            hx--;
            if (gx >= here_x) gx--; else gx++;
         end
         tab_x[found] = gx;
         tab_y[found] = gy;
         visited_cnt++;
         home = home_due();
         legs_due.push_back(make_leg(gx, gy, hx, hy, 0, !home));
         here_x = gx;
         here_y = gy;
      end
      if (home_due())
         legs_due.push_back(make_leg(0, 0, here_x, here_y, 1, 1));
   endfunction

   // ---- result checker ----
   always @(posedge clock) begin
      leg_t e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (legs_due.size() == 0) begin
            $display("%0t: unexpected leg h=%0d d=%0d", $realtime, rsp_heading,
                     rsp_distance);
            errors++;
         end else begin
            e = legs_due.pop_front();
            if (rsp_heading !== e.heading) begin
               $display("%0t: heading exp %0d got %0d", $realtime, e.heading, rsp_heading);
               errors++;
            end
            if (rsp_distance !== e.distance) begin
               $display("%0t: distance exp %0d got %0d", $realtime, e.distance,
                        rsp_distance);
               errors++;
            end
            if (rsp_home_leg !== e.home_leg) begin
               $display("%0t: home_leg exp %0b got %0b", $realtime, e.home_leg,
                        rsp_home_leg);
               errors++;
            end
            if (rsp_last !== e.last) begin
               $display("%0t: last exp %0b got %0b", $realtime, e.last, rsp_last);
               errors++;
            end
         end
      end
   end

   // ---- receiver: mixed stall patterns, one long hold on request ----
   initial begin
      int mode, run;
      bit held;
      rsp_ready = 0;
      held = 0;
      forever begin
         if (hold_go && !held) begin
            // long hold: the block fills and must stall req_ready
            held = 1;
            rsp_ready <= 0;
            repeat (HOLD_LEN) @(posedge clock);
         end
         mode = $urandom_range(0, 2);
         run = $urandom_range(1, 40);
         repeat (run) begin
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 1) == 1);
               default: rsp_ready <= ($urandom_range(0, 7) == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   // ---- sender ----
   task automatic send_item(row_t r);
      int queued;
      req_valid    <= 1'b1;
      req_action   <= r.action;
      req_slot     <= r.slot;
      req_target_x <= r.tx;
      req_target_y <= r.ty;
      req_pending  <= r.pend;
      do @(posedge clock); while (!req_ready);
      queued = legs_due.size();
      plan_step(r.action, r.slot, r.tx, r.ty, r.pend);
      if (r.typed && legs_due.size() > queued) legs_due[queued] = r.leg;
      items_sent++;
   endtask

   // random gap between bursts; valid stays high inside a burst
   int burst_left = 0;
   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // register write only when nothing is in flight
   task automatic set_count(bit [5:0] v);
      req_valid <= 1'b0;
      while (legs_due.size() != 0) @(posedge clock);
      repeat (IDLE_GAP) @(posedge clock);
      csr_valid <= 1'b1;
      csr_target_count <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      route_count = v;
   endtask

   function automatic bit [7:0] pick_coord(bit [7:0] cur);
      case ($urandom_range(0, 5))
         0: return 8'd0;
         1: return 8'd255;
         2: return cur;                               // same axis as position
         3: return cur + 8'($urandom_range(0, 4)) - 8'd2;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   row_t dir_rows [18];

   initial begin
      row_t r;
      int nslots, nload, scan;
      bit [5:0] counts [7];
      counts = '{6'd1, 6'd2, 6'd3, 6'd32, 6'd63, 6'd0, 6'd5};
      // directed table: target count 2 from reset
      dir_rows = '{
         '{0, 5'd0,  8'd0,   8'd0,   1, 0, '{0, 0, 0, 0}},
         // target at position: heading 180, distance 0, then origin leg
         '{1, 5'd0,  8'd0,   8'd0,   0, 1, '{16'sd23040, 17'd0, 0, 0}},
         '{0, 5'd1,  8'd255, 8'd255, 1, 0, '{0, 0, 0, 0}},
         '{1, 5'd0,  8'd0,   8'd0,   0, 0, '{0, 0, 0, 0}},
         '{1, 5'd0,  8'd0,   8'd0,   0, 0, '{0, 0, 0, 0}},  // nothing pending
         '{0, 5'd31, 8'd255, 8'd0,   1, 0, '{0, 0, 0, 0}},  // outside scan
         '{0, 5'd0,  8'd200, 8'd10,  1, 0, '{0, 0, 0, 0}},
         '{1, 5'd0,  8'd0,   8'd0,   0, 0, '{0, 0, 0, 0}},  // left and below
         '{0, 5'd1,  8'd0,   8'd255, 1, 0, '{0, 0, 0, 0}},
         '{1, 5'd0,  8'd0,   8'd0,   0, 0, '{0, 0, 0, 0}},  // left and above
         '{0, 5'd0,  8'd10,  8'd100, 0, 0, '{0, 0, 0, 0}},  // not pending
         '{1, 5'd0,  8'd0,   8'd0,   0, 0, '{0, 0, 0, 0}},
         '{0, 5'd1,  8'd255, 8'd0,   1, 0, '{0, 0, 0, 0}},
         '{1, 5'd0,  8'd0,   8'd0,   0, 0, '{0, 0, 0, 0}},  // right and below
         '{0, 5'd0,  8'd255, 8'd200, 1, 0, '{0, 0, 0, 0}},
         '{1, 5'd0,  8'd0,   8'd0,   0, 0, '{0, 0, 0, 0}},  // right and above
         '{0, 5'd1,  8'd128, 8'd128, 1, 0, '{0, 0, 0, 0}},
         '{1, 5'd0,  8'd0,   8'd0,   0, 0, '{0, 0, 0, 0}}   // left and below
      };

      reset = 1;
      csr_valid = 0;
      csr_target_count = '0;
      req_valid = 0;
      req_action = 0;
      req_slot = '0;
      req_target_x = '0;
      req_target_y = '0;
      req_pending = 0;
      route_count = 0;
      here_x = 0;
      here_y = 0;
      visited_cnt = 0;
      foreach (tab_pend[i]) tab_pend[i] = 0;
      repeat (8) @(posedge clock);
      reset <= 0;

      set_count(6'd2);
      foreach (dir_rows[i]) begin
         pace();
         send_item(dir_rows[i]);
      end

      // random route phases
      for (int ph = 0; items_sent < ITEM_GOAL; ph++) begin
         if (ph < 7) set_count(counts[ph]);
         else if (ph % 2 == 0) set_count(visited_cnt + 6'd1 + 6'($urandom_range(0, 3)));
         else set_count(6'($urandom_range(0, 63)));
         if (ph == 3) hold_go = 1;
         scan = (route_count < 32) ? route_count : 32;
         repeat (10) begin
            if ($urandom_range(0, 4) == 0) begin
               // noise: any field values
               r.action = $urandom_range(0, 1);
               r.slot   = $urandom_range(0, 31);
               r.tx     = $urandom_range(0, 255);
               r.ty     = $urandom_range(0, 255);
               r.pend   = $urandom_range(0, 1);
               r.typed  = 0;
               pace();
               send_item(r);
            end else begin
               // load a few targets inside the scan window, then plan
               nload = $urandom_range(1, 4);
               nslots = (scan == 0) ? 32 : scan;
               repeat (nload) begin
                  r.action = ACT_LOAD;
                  r.slot   = $urandom_range(0, nslots - 1);
                  r.tx     = pick_coord(here_x);
                  r.ty     = pick_coord(here_y);
                  r.pend   = ($urandom_range(0, 7) != 0);
                  r.typed  = 0;
                  pace();
                  send_item(r);
               end
               repeat ($urandom_range(1, nload + 1)) begin
                  r.action = ACT_PLAN;
                  r.slot   = $urandom_range(0, 31);
                  r.tx     = $urandom_range(0, 255);
                  r.ty     = $urandom_range(0, 255);
                  r.pend   = $urandom_range(0, 1);
                  pace();
                  send_item(r);
               end
            end
         end
      end

      req_valid <= 1'b0;
      while (legs_due.size() != 0) @(posedge clock);
      repeat (IDLE_GAP) @(posedge clock);
      if (errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
`default_nettype wire
